### rtl/qgp_pkg.sv
// ----------------------------------------------------------------------------
// qgp_pkg
// Shared types and constants for the quaternion gravity projection pipeline.
// ----------------------------------------------------------------------------
package qgp_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 16;
  localparam int PROD_W        = 32;
  localparam int SUM_W         = 33;
  localparam int MAG_W         = 33;
  localparam int DEN_W         = 33;
  localparam int LANES         = 3;

  typedef struct packed {
    logic signed [IN_W-1:0] quat_w;
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] grav_x;
    logic signed [OUT_W-1:0] grav_y;
    logic signed [OUT_W-1:0] grav_z;
    logic                    zero_norm;
  } grav_t;

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zero;
  } side_t;

endpackage

### rtl/qgp_front.sv
// ----------------------------------------------------------------------------
// qgp_front
// Three register stages: component products, partial sums, then squared
// norm, numerator magnitudes and signs.
// ----------------------------------------------------------------------------
module qgp_front (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             en,
  input  logic                                             in_valid,
  input  qgp_pkg::quat_t                                   in_data,
  output logic                                             out_valid,
  output logic [qgp_pkg::DEN_W-1:0]                        den,
  output logic [qgp_pkg::LANES-1:0][qgp_pkg::MAG_W-1:0]    mag,
  output qgp_pkg::side_t                                   side
);

  logic                              v1;
  logic        [qgp_pkg::PROD_W-1:0] ww;
  logic        [qgp_pkg::PROD_W-1:0] xx;
  logic        [qgp_pkg::PROD_W-1:0] yy;
  logic        [qgp_pkg::PROD_W-1:0] zz;
  logic signed [qgp_pkg::PROD_W-1:0] p_xz;
  logic signed [qgp_pkg::PROD_W-1:0] p_yw;
  logic signed [qgp_pkg::PROD_W-1:0] p_yz;
  logic signed [qgp_pkg::PROD_W-1:0] p_xw;

  logic                              v2;
  logic        [qgp_pkg::PROD_W-1:0] sa;
  logic        [qgp_pkg::PROD_W-1:0] sb;
  logic        [qgp_pkg::SUM_W-1:0]  sc;
  logic        [qgp_pkg::SUM_W-1:0]  sd;

  logic        [qgp_pkg::SUM_W-1:0]  abs_c;
  logic        [qgp_pkg::SUM_W-1:0]  abs_d;

  assign abs_c = sc[qgp_pkg::SUM_W-1] ? (~sc + 1'b1) : sc;
  assign abs_d = sd[qgp_pkg::SUM_W-1] ? (~sd + 1'b1) : sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww   <= in_data.quat_w * in_data.quat_w;
      xx   <= in_data.quat_x * in_data.quat_x;
      yy   <= in_data.quat_y * in_data.quat_y;
      zz   <= in_data.quat_z * in_data.quat_z;
      p_xz <= in_data.quat_x * in_data.quat_z;
      p_yw <= in_data.quat_y * in_data.quat_w;
      p_yz <= in_data.quat_y * in_data.quat_z;
      p_xw <= in_data.quat_x * in_data.quat_w;

      sa <= xx + yy;
      sb <= ww + zz;
      sc <= {p_xz[qgp_pkg::PROD_W-1], p_xz} + {p_yw[qgp_pkg::PROD_W-1], p_yw};
      sd <= {p_yz[qgp_pkg::PROD_W-1], p_yz} - {p_xw[qgp_pkg::PROD_W-1], p_xw};

      den       <= {1'b0, sa} + {1'b0, sb};
      mag[0]    <= {abs_c[qgp_pkg::SUM_W-2:0], 1'b0};
      mag[1]    <= {abs_d[qgp_pkg::SUM_W-2:0], 1'b0};
      mag[2]    <= (sa >= sb) ? {1'b0, sa - sb} : {1'b0, sb - sa};
      side.neg  <= {sb > sa,
                    !sd[qgp_pkg::SUM_W-1] && (sd != '0),
                    !sc[qgp_pkg::SUM_W-1] && (sc != '0)};
      side.zero <= (sa == '0) && (sb == '0);
    end
  end

endmodule

### rtl/qgp_div.sv
// ----------------------------------------------------------------------------
// qgp_div
// Pipelined restoring divider, three lanes sharing one divisor: a numerator
// stage adds the rounding half, then one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qgp_div #(
  parameter int FRAC_BITS = qgp_pkg::FRAC_BITS_DEF,
  parameter int Q_W       = FRAC_BITS + 1
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic [qgp_pkg::DEN_W-1:0]                     den,
  input  logic [qgp_pkg::LANES-1:0][qgp_pkg::MAG_W-1:0] mag,
  input  qgp_pkg::side_t                                in_side,
  output logic                                          out_valid,
  output logic [qgp_pkg::LANES-1:0][Q_W-1:0]            quo,
  output qgp_pkg::side_t                                out_side
);

  localparam int STAGES = Q_W;
  localparam int NUM_W  = qgp_pkg::MAG_W + FRAC_BITS + 1;

  logic [STAGES:0]                                  vld;
  logic [STAGES:0][qgp_pkg::DEN_W-1:0]              den_p;
  logic [STAGES:0][qgp_pkg::LANES-1:0][NUM_W-1:0]   rem;
  logic [STAGES:0][qgp_pkg::LANES-1:0][Q_W-1:0]     qp;
  qgp_pkg::side_t [STAGES:0]                        side_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_p[0]  <= den;
      side_p[0] <= in_side;
      for (int l = 0; l < qgp_pkg::LANES; l++) begin
        rem[0][l] <= NUM_W'({mag[l], {FRAC_BITS{1'b0}}})
                   + NUM_W'(den >> 1);
        qp[0][l]  <= '0;
      end
    end
  end

  for (genvar k = 1; k <= STAGES; k++) begin : g_stage
    localparam int SH = STAGES - k;
    logic [NUM_W-1:0]                      dsh;
    logic [qgp_pkg::LANES-1:0]             ge;
    logic [qgp_pkg::LANES-1:0][NUM_W-1:0]  diff;

    assign dsh = NUM_W'(den_p[k-1]) << SH;

    always_comb begin
      for (int l = 0; l < qgp_pkg::LANES; l++) begin
        ge[l]   = rem[k-1][l] >= dsh;
        diff[l] = rem[k-1][l] - dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_p[k]  <= den_p[k-1];
        side_p[k] <= side_p[k-1];
        for (int l = 0; l < qgp_pkg::LANES; l++) begin
          rem[k][l] <= ge[l] ? diff[l] : rem[k-1][l];
          qp[k][l]  <= {qp[k-1][l][Q_W-2:0], ge[l]};
        end
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign quo       = qp[STAGES];
  assign out_side  = side_p[STAGES];

endmodule

### rtl/qgp_out.sv
// ----------------------------------------------------------------------------
// qgp_out
// Output register: saturate each quotient, apply its sign, clamp to 16 bits
// and substitute the fixed result for a zero quaternion.
// ----------------------------------------------------------------------------
module qgp_out #(
  parameter int FRAC_BITS = qgp_pkg::FRAC_BITS_DEF,
  parameter int Q_W       = FRAC_BITS + 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [qgp_pkg::LANES-1:0][Q_W-1:0] quo,
  input  qgp_pkg::side_t                     side,
  output logic                               out_valid,
  output qgp_pkg::grav_t                     out_data
);

  localparam int CW = (Q_W > qgp_pkg::OUT_W + 1) ? Q_W : qgp_pkg::OUT_W + 1;
  localparam logic [CW-1:0] ONE_C   = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] POS_LIM = CW'((1 << (qgp_pkg::OUT_W - 1)) - 1);
  localparam logic [CW-1:0] NEG_LIM = CW'(1 << (qgp_pkg::OUT_W - 1));
  localparam logic [CW-1:0] ZMAG    = (ONE_C > NEG_LIM) ? NEG_LIM : ONE_C;

  logic [qgp_pkg::LANES-1:0][qgp_pkg::OUT_W-1:0] val;

  always_comb begin
    logic [CW-1:0] r;
    logic [CW-1:0] lim;
    logic [CW-1:0] m;
    for (int l = 0; l < qgp_pkg::LANES; l++) begin
      r      = CW'(quo[l]);
      r      = (r > ONE_C) ? ONE_C : r;
      lim    = side.neg[l] ? NEG_LIM : POS_LIM;
      m      = (r > lim) ? lim : r;
      val[l] = side.neg[l] ? (~m[qgp_pkg::OUT_W-1:0] + 1'b1) : m[qgp_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.zero_norm <= side.zero;
      if (side.zero) begin
        out_data.grav_x <= '0;
        out_data.grav_y <= '0;
        out_data.grav_z <= ~ZMAG[qgp_pkg::OUT_W-1:0] + 1'b1;
      end else begin
        out_data.grav_x <= val[0];
        out_data.grav_y <= val[1];
        out_data.grav_z <= val[2];
      end
    end
  end

endmodule

### rtl/quaternion_gravity_projection.sv
// ----------------------------------------------------------------------------
// quaternion_gravity_projection
// Rotates world gravity [0,0,-1] into the body frame of an attitude
// quaternion, normalizing by one pipelined division by the squared norm.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle when not stalled; the divider resolves one
// quotient bit per stage across FRAC_BITS + 1 stages; all stages advance
// together. A stalled output holds the whole pipeline; ready is low only then.
// Reset clears every stage valid bit; no clearing pass, ready right after.
module quaternion_gravity_projection #(
  parameter int FRAC_BITS = qgp_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           quat_valid,
  output logic           quat_ready,
  input  qgp_pkg::quat_t quat,
  output logic           grav_valid,
  input  logic           grav_ready,
  output qgp_pkg::grav_t grav
);

  localparam int Q_W = FRAC_BITS + 1;

  logic                                          en;
  logic                                          f_valid;
  logic [qgp_pkg::DEN_W-1:0]                     f_den;
  logic [qgp_pkg::LANES-1:0][qgp_pkg::MAG_W-1:0] f_mag;
  qgp_pkg::side_t                                f_side;
  logic                                          d_valid;
  logic [qgp_pkg::LANES-1:0][Q_W-1:0]            d_quo;
  qgp_pkg::side_t                                d_side;

  assign en         = !grav_valid || grav_ready;
  assign quat_ready = en;

  qgp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (quat_valid),
    .in_data   (quat),
    .out_valid (f_valid),
    .den       (f_den),
    .mag       (f_mag),
    .side      (f_side)
  );

  qgp_div #(
    .FRAC_BITS (FRAC_BITS),
    .Q_W       (Q_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .den       (f_den),
    .mag       (f_mag),
    .in_side   (f_side),
    .out_valid (d_valid),
    .quo       (d_quo),
    .out_side  (d_side)
  );

  qgp_out #(
    .FRAC_BITS (FRAC_BITS),
    .Q_W       (Q_W)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .quo       (d_quo),
    .side      (d_side),
    .out_valid (grav_valid),
    .out_data  (grav)
  );

endmodule

### rtl/qgp_checker.sv
// ----------------------------------------------------------------------------
// qgp_checker
// Port-level checks for the quaternion gravity projection, bound to the top.
// ----------------------------------------------------------------------------
module qgp_checker #(
  parameter int FRAC_BITS = qgp_pkg::FRAC_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           quat_valid,
  input logic           quat_ready,
  input qgp_pkg::quat_t quat,
  input logic           grav_valid,
  input logic           grav_ready,
  input qgp_pkg::grav_t grav
);

  localparam int LIM_HI = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
  localparam int LIM_LO = (FRAC_BITS >= 15) ? -32768 : -(1 << FRAC_BITS);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    grav_valid && !grav_ready |=> grav_valid && $stable(grav))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !grav_valid |-> quat_ready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    rst |=> !grav_valid)
    else $error("result valid after reset");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    grav_valid && grav.zero_norm |-> grav.grav_x == '0 && grav.grav_y == '0)
    else $error("zero quaternion gave nonzero x or y");

  a_range: assert property (@(posedge clk) disable iff (rst)
    grav_valid |-> int'(grav.grav_x) <= LIM_HI && int'(grav.grav_x) >= LIM_LO
                && int'(grav.grav_y) <= LIM_HI && int'(grav.grav_y) >= LIM_LO
                && int'(grav.grav_z) <= LIM_HI && int'(grav.grav_z) >= LIM_LO)
    else $error("result outside unit range");

endmodule

bind quaternion_gravity_projection qgp_checker #(.FRAC_BITS(FRAC_BITS)) u_qgp_checker (.*);
